// ===== hdl/fgrs_pkg.sv =====
// Shared types and constants for the frame group reorder scatter unit.
package fgrs_pkg;

  localparam int SIZE_W   = 13;  // frame size registers
  localparam int COUNT_W  = 8;   // large frame count
  localparam int ADDR_W   = 20;  // output group address
  localparam int GPOS_W   = 21;  // bytes consumed in the group
  localparam int TOTAL_W  = 22;  // group byte total, with headroom for the +1 compare
  localparam int PROD_W   = SIZE_W + COUNT_W;

  localparam logic [SIZE_W-1:0] HEADER_BYTES = SIZE_W'(2);

  localparam logic [SIZE_W-1:0]  RST_LARGE_BYTES = SIZE_W'(3);
  localparam logic [COUNT_W-1:0] RST_LARGE_COUNT = COUNT_W'(1);
  localparam logic [SIZE_W-1:0]  RST_SMALL_BYTES = SIZE_W'(0);
  localparam logic               RST_SMALL_COUNT = 1'b0;

  typedef enum logic [1:0] {
    REG_LARGE_BYTES = 2'd0,
    REG_LARGE_COUNT = 2'd1,
    REG_SMALL_BYTES = 2'd2,
    REG_SMALL_COUNT = 2'd3
  } cfg_reg_t;

  // Settings as the datapath sees them: sizes clamped, group total and small base ready.
  typedef struct packed {
    logic [SIZE_W-1:0]  large_len;
    logic [COUNT_W-1:0] large_count;
    logic               small_en;
    logic [SIZE_W-1:0]  small_len;
    logic [TOTAL_W-1:0] group_total;
    logic [ADDR_W-1:0]  small_base;
  } cfg_t;

endpackage

// ===== hdl/fgrs_cfg.sv =====
// Configuration registers and the per-group figures derived from them.
module fgrs_cfg #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [fgrs_pkg::SIZE_W-1:0] cfg_data,
  output fgrs_pkg::cfg_t              cfg
);

  logic [fgrs_pkg::SIZE_W-1:0]  large_bytes, large_bytes_next;
  logic [fgrs_pkg::COUNT_W-1:0] large_count, large_count_next;
  logic [fgrs_pkg::SIZE_W-1:0]  small_bytes, small_bytes_next;
  logic                         small_count, small_count_next;

  logic [fgrs_pkg::SIZE_W-1:0]  le_next;
  logic [fgrs_pkg::SIZE_W-1:0]  se_next;
  logic [fgrs_pkg::PROD_W-1:0]  large_total;
  logic [fgrs_pkg::PROD_W-1:0]  small_base_full;

  function automatic logic [fgrs_pkg::SIZE_W-1:0] clamp_size(
    input logic [fgrs_pkg::SIZE_W-1:0] v
  );
    logic [fgrs_pkg::SIZE_W-1:0] r;
    r = v;
    if (v < fgrs_pkg::HEADER_BYTES) begin
      r = fgrs_pkg::HEADER_BYTES;
    end else if (32'(v) > 32'(MAX_FRAME_BYTES)) begin
      r = fgrs_pkg::SIZE_W'(MAX_FRAME_BYTES);
    end
    return r;
  endfunction

  always_comb begin
    large_bytes_next = large_bytes;
    large_count_next = large_count;
    small_bytes_next = small_bytes;
    small_count_next = small_count;
    if (rst) begin
      large_bytes_next = fgrs_pkg::RST_LARGE_BYTES;
      large_count_next = fgrs_pkg::RST_LARGE_COUNT;
      small_bytes_next = fgrs_pkg::RST_SMALL_BYTES;
      small_count_next = fgrs_pkg::RST_SMALL_COUNT;
    end else if (cfg_write) begin
      unique case (fgrs_pkg::cfg_reg_t'(cfg_index))
        fgrs_pkg::REG_LARGE_BYTES: large_bytes_next = cfg_data;
        fgrs_pkg::REG_LARGE_COUNT: large_count_next = cfg_data[fgrs_pkg::COUNT_W-1:0];
        fgrs_pkg::REG_SMALL_BYTES: small_bytes_next = cfg_data;
        fgrs_pkg::REG_SMALL_COUNT: small_count_next = cfg_data[0];
        default: ;
      endcase
    end
    le_next         = clamp_size(large_bytes_next);
    se_next         = small_count_next ? clamp_size(small_bytes_next) : '0;
    large_total     = fgrs_pkg::PROD_W'(le_next) * fgrs_pkg::PROD_W'(large_count_next);
    small_base_full = fgrs_pkg::PROD_W'(large_count_next) *
                      fgrs_pkg::PROD_W'(le_next - fgrs_pkg::HEADER_BYTES);
  end

  // Derived figures follow the registers in the same edge, so they never lag a write.
  always_ff @(posedge clk) begin
    large_bytes     <= large_bytes_next;
    large_count     <= large_count_next;
    small_bytes     <= small_bytes_next;
    small_count     <= small_count_next;
    cfg.large_len   <= le_next;
    cfg.large_count <= large_count_next;
    cfg.small_en    <= small_count_next;
    cfg.small_len   <= se_next;
    cfg.group_total <= fgrs_pkg::TOTAL_W'(large_total) + fgrs_pkg::TOTAL_W'(se_next);
    cfg.small_base  <= small_base_full[fgrs_pkg::ADDR_W-1:0];
  end

endmodule

// ===== hdl/frame_group_reorder_scatter_unit.sv =====
// Top level: header stripping, slot decode and address generation for frame groups.
//
// Input channel in_valid / in_ready / in_byte carries the raw frame stream, one byte per
// word. Each frame opens with two header bytes; the second is a one-based slot number.
// Output channel out_valid / out_ready carries one word per payload byte: out_byte,
// out_address (position in the reordered group), slot_bad (dropped, slot out of range)
// and group_last (final byte of the group). Header bytes give no word, except a marker
// word with slot_bad and group_last set when a group ends on a header byte.
// Settings are written through cfg_write / cfg_index / cfg_data while the stream is idle;
// the user must see to it, the block does not enforce it. A byte is taken every cycle
// while in_ready is high. Slot multiply once per header, a single add per payload byte.
// A full output register with out_ready low holds its word and drops in_ready; in_ready
// rises again in the cycle the word is taken. Reset (rst, synchronous) loads the default
// settings, empties the output register and starts a new group at its first header byte.
module frame_group_reorder_scatter_unit #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic [fgrs_pkg::ADDR_W-1:0]  out_address,
  output logic                         slot_bad,
  output logic                         group_last,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [fgrs_pkg::SIZE_W-1:0]  cfg_data
);

  fgrs_pkg::cfg_t cfg;

  logic [fgrs_pkg::GPOS_W-1:0] group_position, group_position_next;
  logic [fgrs_pkg::SIZE_W-1:0] frame_position, frame_position_next;
  logic [fgrs_pkg::SIZE_W-1:0] frame_length, frame_length_next;
  logic [7:0]                  first_header_byte, first_header_byte_next;
  logic [fgrs_pkg::ADDR_W-1:0] payload_base, payload_base_next;
  logic                        slot_invalid, slot_invalid_next;

  logic                        accept;
  logic                        gend;
  logic                        is_small;
  logic                        bad_slot;
  logic [fgrs_pkg::PROD_W-1:0] slot_product;
  logic [fgrs_pkg::SIZE_W-1:0] fp_inc;
  logic                        res_valid;
  logic [fgrs_pkg::ADDR_W-1:0] res_address;
  logic                        res_bad;
  logic                        res_last;

  fgrs_cfg #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    gend = (fgrs_pkg::TOTAL_W'(group_position) + fgrs_pkg::TOTAL_W'(1)) >= cfg.group_total;
    is_small = cfg.small_en && (first_header_byte == 8'd1) &&
               ({1'b0, in_byte} == ({1'b0, cfg.large_count} + 9'd1));
    bad_slot = (in_byte == 8'd0) || (in_byte > cfg.large_count);
    slot_product = fgrs_pkg::PROD_W'(in_byte - 8'd1) *
                   fgrs_pkg::PROD_W'(cfg.large_len - fgrs_pkg::HEADER_BYTES);
    fp_inc = frame_position + fgrs_pkg::SIZE_W'(1);

    group_position_next    = group_position;
    frame_position_next    = frame_position;
    frame_length_next      = frame_length;
    first_header_byte_next = first_header_byte;
    payload_base_next      = payload_base;
    slot_invalid_next      = slot_invalid;
    res_valid   = 1'b0;
    res_address = '0;
    res_bad     = 1'b1;
    res_last    = gend;

    if (frame_position == '0) begin
      first_header_byte_next = in_byte;
      frame_position_next    = fgrs_pkg::SIZE_W'(1);
      res_valid              = gend;
    end else if (frame_position == fgrs_pkg::SIZE_W'(1)) begin
      if (is_small) begin
        slot_invalid_next = 1'b0;
        frame_length_next = cfg.small_len;
        payload_base_next = cfg.small_base;
      end else begin
        slot_invalid_next = bad_slot;
        frame_length_next = cfg.large_len;
        payload_base_next = bad_slot ? '0 : slot_product[fgrs_pkg::ADDR_W-1:0];
      end
      res_valid = gend;
      // header-only frame: next byte is a header again
      frame_position_next = (frame_length_next <= fgrs_pkg::HEADER_BYTES) ?
                            '0 : fgrs_pkg::HEADER_BYTES;
    end else begin
      res_valid   = 1'b1;
      res_bad     = slot_invalid;
      res_address = slot_invalid ? '0 :
                    payload_base +
                    fgrs_pkg::ADDR_W'(frame_position - fgrs_pkg::HEADER_BYTES);
      frame_position_next = (fp_inc >= frame_length) ? '0 : fp_inc;
    end

    // group end restarts frame parsing with the next byte
    if (gend) begin
      group_position_next    = '0;
      frame_position_next    = '0;
      frame_length_next      = '0;
      first_header_byte_next = '0;
      payload_base_next      = '0;
      slot_invalid_next      = 1'b0;
    end else begin
      group_position_next = group_position + fgrs_pkg::GPOS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position    <= '0;
      frame_position    <= '0;
      frame_length      <= '0;
      first_header_byte <= '0;
      payload_base      <= '0;
      slot_invalid      <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        group_position    <= group_position_next;
        frame_position    <= frame_position_next;
        frame_length      <= frame_length_next;
        first_header_byte <= first_header_byte_next;
        payload_base      <= payload_base_next;
        slot_invalid      <= slot_invalid_next;
        out_valid         <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word: load on every accepted byte that yields one, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_byte    <= in_byte;
      out_address <= res_address;
      slot_bad    <= res_bad;
      group_last  <= res_last;
    end
  end

endmodule
